// File: hdl/rpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_pkg
// shared types and codes for the rpn stack evaluator
// ----------------------------------------------------------------------------
package rpn_pkg;

	localparam int WORD_W   = 32;
	localparam int DEPTH_W  = 5;
	localparam int DIV_STEPS = 32;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [2:0] {
		CMD_PUSH  = 3'd0,
		CMD_PRINT = 3'd1,
		CMD_ADD   = 3'd2,
		CMD_MUL   = 3'd3,
		CMD_SUB   = 3'd4,
		CMD_DIV   = 3'd5,
		CMD_MIN   = 3'd6,
		CMD_MAX   = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_UNDER   = 2'd1,
		STAT_OVER    = 2'd2,
		STAT_DIVZERO = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_DIV
	} state_t;

	// per-cell move control
	typedef struct packed {
		logic take_up;
		logic take_dn;
	} cell_ctl_t;

endpackage

// File: hdl/rpn_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_cmd_if
// command channel: one parsed token per transaction
// ----------------------------------------------------------------------------
interface rpn_cmd_if;
	logic                valid;
	logic                ready;
	rpn_pkg::cmd_t       command;
	rpn_pkg::word_t      literal;

	modport source (output valid, output command, output literal, input ready);
	modport sink   (input valid, input command, input literal, output ready);
endinterface

// File: hdl/rpn_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_res_if
// result channel: one result per command transaction
// ----------------------------------------------------------------------------
interface rpn_res_if;
	logic                              valid;
	logic                              ready;
	logic                              printed;
	rpn_pkg::word_t                    print_value;
	rpn_pkg::status_t                  status;
	logic [rpn_pkg::DEPTH_W-1:0]       depth_now;

	modport source (output valid, output printed, output print_value, output status,
		output depth_now, input ready);
	modport sink   (input valid, input printed, input print_value, input status,
		input depth_now, output ready);
endinterface

// File: hdl/rpn_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_cell
// one stack entry; loads from the neighbor above or below
// ----------------------------------------------------------------------------
module rpn_cell (
	input  logic                  clk,
	input  rpn_pkg::cell_ctl_t    ctl,
	input  rpn_pkg::word_t        up,
	input  rpn_pkg::word_t        dn,
	output rpn_pkg::word_t        q
);
	import rpn_pkg::*;

	word_t val_q;

	always_ff @(posedge clk) begin
		if (ctl.take_up) begin
			val_q <= up;
		end else if (ctl.take_dn) begin
			val_q <= dn;
		end
	end

	assign q = val_q;

endmodule

// File: hdl/rpn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_div
// signed truncating divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rpn_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rpn_pkg::word_t    dividend,
	input  rpn_pkg::word_t    divisor,
	output logic              done,
	output rpn_pkg::word_t    quotient
);
	import rpn_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               neg_q;
	logic [WORD_W-1:0]  dq_q;
	logic [WORD_W-1:0]  dm_q;
	logic [WORD_W:0]    rem_q;
	logic [WORD_W:0]    rem_sh;
	logic               ge;

	assign rem_sh = {rem_q[WORD_W-1:0], dq_q[WORD_W-1]};
	assign ge     = rem_sh >= {1'b0, dm_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
			dq_q  <= dividend[WORD_W-1] ? -dividend : dividend;
			dm_q  <= divisor[WORD_W-1] ? -divisor : divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - {1'b0, dm_q}) : rem_sh;
			dq_q  <= {dq_q[WORD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -dq_q : dq_q;

endmodule

// File: hdl/rpn_stack_evaluator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_core
// reverse-polish integer stack machine built as a chain of stack cells
// push, print, add, multiply, subtract, min, max and errors: result registered from the accepted command
// divide: runs in the bit-serial divider, then the quotient replaces the top two cells
// one command at a time; one per cycle while the result channel is free, none taken during divide
// reset: arst_n clears the depth count, fsm and result valid; cells are not cleared
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_core #(
	parameter int STACK_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	rpn_cmd_if.sink   cmd,
	rpn_res_if.source res
);
	import rpn_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);

	state_t            state_q;
	state_t            state_d;
	logic [CW-1:0]     count_q;
	word_t             cell_q [STACK_DEPTH];
	word_t             top;
	word_t             nxt;

	logic              in_fire;
	logic              out_free;
	logic              is_full;
	logic              under_one;
	logic              under_two;
	logic              div_start;
	logic              div_done;
	word_t             div_q;

	logic              do_push;
	logic              do_pop;
	logic              do_repl;
	word_t             repl_val;
	word_t             alu_val;
	cell_ctl_t         head_ctl;
	cell_ctl_t         tail_ctl;

	logic              res_load;
	logic              res_printed;
	word_t             res_pval;
	status_t           res_status;
	logic [CW-1:0]     res_count;

	logic              out_valid_q;
	logic              printed_q;
	word_t             pval_q;
	status_t           status_q;
	logic [CW-1:0]     depth_q;

	assign top       = cell_q[0];
	assign nxt       = cell_q[1];
	assign out_free  = !out_valid_q || res.ready;
	assign in_fire   = cmd.valid && cmd.ready;
	assign is_full   = count_q == CW'(STACK_DEPTH);
	assign under_one = count_q == '0;
	assign under_two = count_q <= CW'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (div_start) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		cmd.ready = 1'b0;
		case (state_q)
			S_IDLE:  cmd.ready = out_free;
			S_DIV:   cmd.ready = 1'b0;
			default: cmd.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// combinational operators
	always_comb begin
		case (cmd.command)
			CMD_ADD: alu_val = nxt + top;
			CMD_MUL: alu_val = WORD_W'(nxt * top);
			CMD_SUB: alu_val = nxt - top;
			CMD_MIN: alu_val = (top < nxt) ? top : nxt;
			CMD_MAX: alu_val = (nxt < top) ? top : nxt;
			default: alu_val = nxt;
		endcase
	end

	// command decode
	always_comb begin
		do_push     = 1'b0;
		do_pop      = 1'b0;
		do_repl     = 1'b0;
		div_start   = 1'b0;
		repl_val    = alu_val;
		res_load    = 1'b0;
		res_printed = 1'b0;
		res_pval    = '0;
		res_status  = STAT_OK;
		res_count   = count_q;
		if (div_done) begin
			do_repl   = 1'b1;
			repl_val  = div_q;
			res_load  = 1'b1;
			res_count = count_q - CW'(1);
		end else if (in_fire) begin
			case (cmd.command)
				CMD_PUSH: begin
					res_load = 1'b1;
					if (is_full) begin
						res_status = STAT_OVER;
					end else begin
						do_push   = 1'b1;
						res_count = count_q + CW'(1);
					end
				end
				CMD_PRINT: begin
					res_load = 1'b1;
					if (under_one) begin
						res_status = STAT_UNDER;
					end else begin
						do_pop      = 1'b1;
						res_printed = 1'b1;
						res_pval    = top;
						res_count   = count_q - CW'(1);
					end
				end
				default: begin
					if (under_two) begin
						res_load   = 1'b1;
						res_status = STAT_UNDER;
					end else if (cmd.command == CMD_DIV && top == '0) begin
						res_load   = 1'b1;
						res_status = STAT_DIVZERO;
					end else if (cmd.command == CMD_DIV) begin
						div_start = 1'b1;
					end else begin
						res_load  = 1'b1;
						do_repl   = 1'b1;
						res_count = count_q - CW'(1);
					end
				end
			endcase
		end
	end

	// cell moves: the head takes a new value, the tail shifts
	always_comb begin
		head_ctl.take_up = do_push || do_repl;
		head_ctl.take_dn = do_pop;
		tail_ctl.take_up = do_push;
		tail_ctl.take_dn = do_pop || do_repl;
	end

	rpn_cell u_head (
		.clk (clk),
		.ctl (head_ctl),
		.up  (do_push ? cmd.literal : repl_val),
		.dn  (cell_q[1]),
		.q   (cell_q[0])
	);

	for (genvar i = 1; i < STACK_DEPTH; i++) begin : g_cell
		rpn_cell u_cell (
			.clk (clk),
			.ctl (tail_ctl),
			.up  (cell_q[i-1]),
			.dn  ((i == STACK_DEPTH - 1) ? word_t'(0) : cell_q[(i + 1) % STACK_DEPTH]),
			.q   (cell_q[i])
		);
	end

	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (nxt),
		.divisor  (top),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= res_count;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			printed_q <= res_printed;
			pval_q    <= res_pval;
			status_q  <= res_status;
			depth_q   <= res_count;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.printed     = printed_q;
	assign res.print_value = pval_q;
	assign res.status      = status_q;
	assign res.depth_now   = DEPTH_W'(depth_q);

	// checks
	a_busy_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> !cmd.ready)
		else $error("command transaction accepted during divide");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count above depth");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside divide state");

	a_push_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && cmd.command == CMD_PUSH && !is_full) |=>
		count_q == $past(count_q) + CW'(1))
		else $error("push did not grow the stack");

endmodule

// File: dv/rpn_stack_evaluator_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_core_test
// self-checking bench for the rpn stack evaluator: a tracker class keeps its
// own stack and predicts every result, tokens come as directed corner cases
// and then as random expressions, fills, drains and noise, with random idling
// on both channels and one long result stall
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_core_test;
	import rpn_pkg::*;

	typedef struct {
		logic               printed;
		word_t              print_value;
		status_t            status;
		logic [DEPTH_W-1:0] depth_now;
	} rpn_result_t;

	class rpn_stack_tracker #(int STACK_LIMIT = 16);
		word_t       stack_mem[STACK_LIMIT];
		int unsigned stack_count;
		rpn_result_t expected_q[$];
		int          mismatches;
		int          tokens_seen;
		int          results_seen;
		int          printed_seen;
		int          status_seen[4];

		function new();
			stack_count = 0;
			mismatches = 0;
			tokens_seen = 0;
			results_seen = 0;
			printed_seen = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function logic [WORD_W-1:0] trunc_div(logic [WORD_W-1:0] n,
				logic [WORD_W-1:0] d);
			logic [WORD_W-1:0] n_mag;
			logic [WORD_W-1:0] d_mag;
			logic [WORD_W-1:0] q;
			n_mag = n[WORD_W-1] ? -n : n;
			d_mag = d[WORD_W-1] ? -d : d;
			q = n_mag / d_mag;
			return (n[WORD_W-1] != d[WORD_W-1]) ? -q : q;
		endfunction

		function void note_token(cmd_t c, word_t lit);
			rpn_result_t r;
			word_t       top;
			word_t       below;
			word_t       acc;
			r.printed = 1'b0;
			r.print_value = '0;
			r.status = STAT_OK;
			acc = '0;
			tokens_seen++;
			case (c)
				CMD_PUSH: begin
					if (stack_count >= STACK_LIMIT) begin
						r.status = STAT_OVER;
					end else begin
						stack_mem[stack_count] = lit;
						stack_count++;
					end
				end
				CMD_PRINT: begin
					if (stack_count < 1) begin
						r.status = STAT_UNDER;
					end else begin
						stack_count--;
						r.print_value = stack_mem[stack_count];
						r.printed = 1'b1;
					end
				end
				default: begin
					if (stack_count < 2) begin
						r.status = STAT_UNDER;
					end else begin
						top = stack_mem[stack_count-1];
						below = stack_mem[stack_count-2];
						case (c)
							CMD_ADD: acc = below + top;
							CMD_MUL: acc = below * top;
							CMD_SUB: acc = below - top;
							CMD_DIV: begin
								if (top == 0) r.status = STAT_DIVZERO;
								else acc = trunc_div(below, top);
							end
							CMD_MIN: acc = (top < below) ? top : below;
							default: acc = (below < top) ? top : below;
						endcase
						if (r.status == STAT_OK) begin
							stack_count--;
							stack_mem[stack_count-1] = acc;
						end
					end
				end
			endcase
			r.depth_now = DEPTH_W'(stack_count);
			expected_q.insert(expected_q.size(), r);
		endfunction

		function void check_result(logic printed, word_t value, status_t status,
				logic [DEPTH_W-1:0] depth);
			rpn_result_t e;
			results_seen++;
			if (printed === 1'b1) printed_seen++;
			if (!$isunknown(status)) status_seen[int'(status)]++;
			if (expected_q.size() == 0) begin
				$error("result transaction with no pending expectation");
				mismatches++;
				return;
			end
			e = expected_q.pop_front();
			if (printed !== e.printed) begin
				$error("printed: expected %0d, actual %0d", e.printed, printed);
				mismatches++;
			end
			if (value !== e.print_value) begin
				$error("print_value: expected %0d, actual %0d", e.print_value, value);
				mismatches++;
			end
			if (status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, status);
				mismatches++;
			end
			if (depth !== e.depth_now) begin
				$error("depth_now: expected %0d, actual %0d", e.depth_now, depth);
				mismatches++;
			end
		endfunction
	endclass

	localparam int    STACK_LIMIT = 16;
	localparam int    DIRECTED_COUNT = 22;
	localparam int    RANDOM_COUNT = 1300;
	localparam int    LONG_HOLD = 200;
	localparam word_t WORD_MAX = 32'sh7fffffff;
	localparam word_t WORD_MIN = 32'sh80000000;

	logic clk;
	logic arst_n;
	bit   quiet;
	bit   hold_req;
	int   sent;

	rpn_cmd_if cmd_ch ();
	rpn_res_if res_ch ();

	rpn_stack_tracker #(STACK_LIMIT) tracker;

	rpn_stack_evaluator_core #(
		.STACK_DEPTH(STACK_LIMIT)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.res   (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic word_t pick_literal();
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 4))
					0: return WORD_MAX;
					1: return WORD_MIN;
					2: return '0;
					3: return -1;
					default: return 1;
				endcase
			end
			1, 2: return word_t'($urandom_range(0, 40)) - 20;
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic cmd_t pick_operator();
		return cmd_t'($urandom_range(2, 7));
	endfunction

	task automatic send_token(cmd_t c, word_t v);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= c;
		cmd_ch.literal <= v;
		@(posedge clk);
		while (cmd_ch.ready !== 1'b1) @(posedge clk);
		tracker.note_token(c, v);
		sent++;
	endtask

	task automatic run_expression(int len);
		int pick;
		repeat (len) begin
			pick = $urandom_range(0, 9);
			if (tracker.stack_count < 2) begin
				send_token(CMD_PUSH, pick_literal());
			end else if (tracker.stack_count >= STACK_LIMIT || pick >= 5) begin
				if (pick == 9) send_token(CMD_PRINT, pick_literal());
				else send_token(pick_operator(), pick_literal());
			end else begin
				send_token(CMD_PUSH, pick_literal());
			end
		end
		while (tracker.stack_count > 1 && $urandom_range(0, 3) != 0)
			send_token(pick_operator(), pick_literal());
		send_token(CMD_PRINT, pick_literal());
	endtask

	task automatic fill_stack();
		while (tracker.stack_count < STACK_LIMIT)
			send_token(CMD_PUSH, pick_literal());
		repeat ($urandom_range(1, 2)) send_token(CMD_PUSH, pick_literal());
		repeat ($urandom_range(3, 10)) begin
			if ($urandom_range(0, 3) == 0) send_token(CMD_PRINT, pick_literal());
			else send_token(pick_operator(), pick_literal());
		end
	endtask

	task automatic drain_stack();
		while (tracker.stack_count > 0)
			send_token(CMD_PRINT, pick_literal());
		send_token(CMD_PRINT, pick_literal());
		send_token(pick_operator(), pick_literal());
	endtask

	initial begin
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				res_ch.ready <= 1'b0;
				for (int hold_count = 0; hold_count < LONG_HOLD; hold_count++)
					@(posedge clk);
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
			tracker.check_result(res_ch.printed, res_ch.print_value, res_ch.status,
				res_ch.depth_now);
	end

	initial begin
		int kind;
		tracker = new();
		quiet = 1'b0;
		hold_req = 1'b0;
		sent = 0;
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.command <= CMD_PUSH;
		cmd_ch.literal <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// corner cases: underflow, wraps, divide by zero, truncation
		send_token(CMD_PRINT, WORD_MAX);
		send_token(CMD_ADD, WORD_MIN);
		send_token(CMD_PUSH, WORD_MIN);
		send_token(CMD_SUB, '0);
		send_token(CMD_PUSH, -1);
		send_token(CMD_DIV, -1);
		send_token(CMD_PUSH, '0);
		send_token(CMD_DIV, '0);
		send_token(CMD_PRINT, '0);
		send_token(CMD_PUSH, -1);
		send_token(CMD_ADD, '0);
		send_token(CMD_PUSH, WORD_MAX);
		send_token(CMD_MUL, '0);
		send_token(CMD_PUSH, WORD_MIN);
		send_token(CMD_SUB, '0);
		send_token(CMD_PUSH, -2);
		send_token(CMD_MIN, '0);
		send_token(CMD_PUSH, 5);
		send_token(CMD_MAX, '0);
		send_token(CMD_PUSH, -2);
		send_token(CMD_DIV, '0);
		send_token(CMD_PRINT, '0);

		hold_req = 1'b1;
		while (sent < DIRECTED_COUNT + RANDOM_COUNT) begin
			if (sent > DIRECTED_COUNT + RANDOM_COUNT * 85 / 100) quiet = 1'b1;
			kind = $urandom_range(0, 9);
			if (kind <= 5) run_expression($urandom_range(2, 16));
			else if (kind == 6) fill_stack();
			else if (kind == 7) drain_stack();
			else begin
				repeat ($urandom_range(1, 8))
					send_token(cmd_t'($urandom_range(0, 7)), pick_literal());
			end
		end
		cmd_ch.valid <= 1'b0;

		while (tracker.expected_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d tokens and %0d results, %0d of them printed values",
			tracker.tokens_seen, tracker.results_seen, tracker.printed_seen);
		$display("status mix: ok %0d, underflow %0d, overflow %0d, divide by zero %0d",
			tracker.status_seen[STAT_OK], tracker.status_seen[STAT_UNDER],
			tracker.status_seen[STAT_OVER], tracker.status_seen[STAT_DIVZERO]);
		if (tracker.mismatches == 0 && tracker.expected_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/rpn_pkg.sv
hdl/rpn_cmd_if.sv
hdl/rpn_res_if.sv
hdl/rpn_cell.sv
hdl/rpn_div.sv
hdl/rpn_stack_evaluator_core.sv
dv/rpn_stack_evaluator_core_test.sv
